// File: rtl/dmtm_pkg.sv
// Shared types, constants and helpers of the depth map to triangle mesh block.
// Used by every RTL module of the block except dmtm_ram, and by its port checker.
package dmtm_pkg;

	// Default capacity of the line store in pixels.
	localparam int MAX_WIDTH_DEF = 2048;

	localparam int IMAGE_WIDTH_W = 12;
	localparam int ROW_W = 16;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	// Fraction bits of the Q8.24 intrinsic terms.
	localparam int QFRAC = 24;

	localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RST = 12'd640;
	localparam logic signed [33:0] ONE_Q16 = 34'sd65536;
	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH = 3'd0,
		REG_SCALE_X     = 3'd1,
		REG_OFFSET_X    = 3'd2,
		REG_SCALE_Y     = 3'd3,
		REG_OFFSET_Y    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] scale_x;
		logic signed [31:0] offset_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] offset_y;
	} coef_t;

	typedef struct packed {
		logic        depth_valid;
		logic [31:0] depth;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} pixel_t;

	// The four corners of a quad: row above / current row, left / right column.
	typedef struct packed {
		pixel_t p00;
		pixel_t p01;
		pixel_t p10;
		pixel_t p11;
	} quad_t;

	typedef enum logic [1:0] {
		CRN_00,
		CRN_01,
		CRN_10,
		CRN_11
	} corner_t;

	typedef logic [2:0] slot_t;

	localparam slot_t SLOT_FIRST = 3'd0;
	localparam slot_t SLOT_LAST  = 3'd5;

	// Vertex order of the two triangles: v00, v11, v01, then v11, v00, v10.
	function automatic corner_t slot_corner(slot_t s);
		corner_t c;
		unique case (s)
			3'd0:    c = CRN_00;
			3'd1:    c = CRN_11;
			3'd2:    c = CRN_01;
			3'd3:    c = CRN_11;
			3'd4:    c = CRN_00;
			3'd5:    c = CRN_10;
			default: c = CRN_00;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/dmtm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module dmtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/dmtm_front.sv
// Front end: takes pixels, tracks row and column, keeps the line store and
// picks out quads whose four corners are valid. Uses dmtm_pkg and dmtm_ram.
module dmtm_front #(
	parameter int MAX_WIDTH = dmtm_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dmtm_pkg::IMAGE_WIDTH_W-1:0]  image_width,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  logic [31:0]                         depth,
	input  logic                                depth_valid,
	input  logic [15:0]                         red,
	input  logic [15:0]                         green,
	input  logic [15:0]                         blue,
	input  logic                                frame_start,
	output logic                                push,
	output logic [$clog2(MAX_WIDTH)-1:0]        push_col,
	output logic [dmtm_pkg::ROW_W-1:0]          push_row,
	output dmtm_pkg::quad_t                     push_quad,
	input  logic                                q_full
);
	import dmtm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > IMAGE_WIDTH_W) ? WW : IMAGE_WIDTH_W;
	localparam int PIX_W = $bits(pixel_t);

	function automatic logic [ROW_W-1:0] row_step(logic [ROW_W-1:0] r);
		return (r == '1) ? r : r + ROW_W'(1);
	endfunction

	logic [CMPW-1:0]  iw_ext;
	logic [WW-1:0]    w_eff;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             col_wrap;
	logic [CW-1:0]    c_now;
	logic [ROW_W-1:0] r_now;
	logic [WW-1:0]    c_next;
	logic             end_row;
	logic [CW-1:0]    wr_addr;
	logic             accept;
	pixel_t           pix_in;
	pixel_t           left_q;
	pixel_t           up_left_q;
	pixel_t           ram_q;
	logic [PIX_W-1:0] ram_rd_data;

	logic             vld_s1;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	pixel_t           pix_s1;
	pixel_t           left_s1;
	logic             quad_s1;
	logic             adv_s1;

	// Effective width, clamped to at least two and to what the line store can hold.
	always_comb begin
		iw_ext = CMPW'(image_width);
		if (iw_ext < CMPW'(2)) begin
			w_eff = WW'(2);
		end else if (iw_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(iw_ext);
		end
	end

	// Frame start zeroes row and column; a column count left beyond a narrowed width starts a new row.
	always_comb begin
		col_wrap = WW'(col_q) >= w_eff;
		if (frame_start) begin
			c_now = '0;
			r_now = '0;
		end else if (col_wrap) begin
			c_now = '0;
			r_now = row_step(row_q);
		end else begin
			c_now = col_q;
			r_now = row_q;
		end
		c_next  = WW'(c_now) + WW'(1);
		end_row = c_next >= w_eff;
		// The left pixel is written back one step late; at column zero it ends the row above.
		wr_addr = (c_now != '0) ? c_now - CW'(1) : CW'(w_eff - WW'(1));
	end

	assign pix_in = {depth_valid, depth, red, green, blue};
	assign accept = pixel_valid && !pixel_stall;

	dmtm_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(wr_addr),
		.wr_data(left_q),
		.rd_en  (accept),
		.rd_addr(c_now),
		.rd_data(ram_rd_data)
	);

	assign ram_q = pixel_t'(ram_rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				col_q  <= end_row ? '0 : c_next[CW-1:0];
				row_q  <= end_row ? row_step(r_now) : r_now;
				left_q <= pix_in;
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= c_now;
			row_s1  <= r_now;
			pix_s1  <= pix_in;
			left_s1 <= left_q;
		end
		// The entry above this pixel is the upper left corner of the next one.
		if (adv_s1) begin
			up_left_q <= ram_q;
		end
	end

	assign quad_s1 = vld_s1 && (row_s1 != '0) && (col_s1 != '0)
		&& up_left_q.depth_valid && ram_q.depth_valid
		&& left_s1.depth_valid && pix_s1.depth_valid;

	assign pixel_stall = vld_s1 && quad_s1 && q_full;
	assign adv_s1      = vld_s1 && !pixel_stall;

	assign push      = quad_s1 && !q_full;
	assign push_col  = col_s1;
	assign push_row  = row_s1;
	assign push_quad = '{p00: up_left_q, p01: ram_q, p10: left_s1, p11: pix_s1};

endmodule

// File: rtl/dmtm_queue.sv
// Short queue of quads between the front end and the vertex pipeline.
// Uses dmtm_pkg.
module dmtm_queue #(
	parameter int MAX_WIDTH = dmtm_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [$clog2(MAX_WIDTH)-1:0]  push_col,
	input  logic [dmtm_pkg::ROW_W-1:0]    push_row,
	input  dmtm_pkg::quad_t               push_quad,
	output logic                          full,
	input  logic                          pop,
	output logic                          empty,
	output logic [$clog2(MAX_WIDTH)-1:0]  head_col,
	output logic [dmtm_pkg::ROW_W-1:0]    head_row,
	output dmtm_pkg::quad_t               head_quad
);
	import dmtm_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]    col_mem  [QUEUE_DEPTH];
	logic [ROW_W-1:0] row_mem  [QUEUE_DEPTH];
	quad_t            quad_mem [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	function automatic logic [QAW-1:0] ptr_step(logic [QAW-1:0] p);
		return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
	endfunction

	assign full  = count_q == QCW'(QUEUE_DEPTH);
	assign empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_step(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_step(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			col_mem[wr_ptr_q]  <= push_col;
			row_mem[wr_ptr_q]  <= push_row;
			quad_mem[wr_ptr_q] <= push_quad;
		end
	end

	assign head_col  = col_mem[rd_ptr_q];
	assign head_row  = row_mem[rd_ptr_q];
	assign head_quad = quad_mem[rd_ptr_q];

endmodule

// File: rtl/dmtm_back.sv
// Vertex pipeline: walks the six vertices of each queued quad and unprojects
// them into saturated Q16.16 positions, one per cycle while the output is not stalled. Uses dmtm_pkg.
module dmtm_back #(
	parameter int MAX_WIDTH = dmtm_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dmtm_pkg::coef_t               coef,
	input  logic                          empty,
	output logic                          pop,
	input  logic [$clog2(MAX_WIDTH)-1:0]  head_col,
	input  logic [dmtm_pkg::ROW_W-1:0]    head_row,
	input  dmtm_pkg::quad_t               head_quad,
	output logic                          vertex_valid,
	input  logic                          vertex_stall,
	output logic signed [31:0]            vertex_x,
	output logic signed [31:0]            vertex_y,
	output logic signed [31:0]            vertex_z,
	output logic [15:0]                   vertex_red,
	output logic [15:0]                   vertex_green,
	output logic [15:0]                   vertex_blue,
	output logic [2:0]                    vertex_slot,
	output logic                          quad_last
);
	import dmtm_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int MXW = 32 + CW + 1;
	localparam int MYW = 32 + ROW_W + 1;
	localparam int AXW = MXW + 1;
	localparam int AYW = MYW + 1;
	localparam int HXW = AXW - QFRAC + 33;
	localparam int HYW = AYW - QFRAC + 33;
	localparam int LW  = QFRAC + 32 + 1;
	localparam int RXW = HXW + 1;
	localparam int RYW = HYW + 1;
	localparam int NYW = RYW + 1;
	localparam logic [QFRAC-1:0] HALF    = {1'b1, {(QFRAC - 1){1'b0}}};
	localparam logic [QFRAC-1:0] HALF_M1 = {1'b0, {(QFRAC - 1){1'b1}}};

	logic    en;
	logic    issue;
	slot_t   slot_q;
	corner_t crn;
	pixel_t  sel_pix;
	logic [CW-1:0]    sel_col;
	logic [ROW_W-1:0] sel_row;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [31:0]      z_s1, z_s2, z_s3;
	logic [47:0]      rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5, rgb_s6;
	slot_t            slot_s1, slot_s2, slot_s3, slot_s4, slot_s5, slot_s6;

	logic signed [MXW-1:0] mx_s2;
	logic signed [MYW-1:0] my_s2;
	logic signed [33:0]    dz;
	logic [31:0]           vz_s2_d;
	logic [31:0]           vz_s2, vz_s3, vz_s4, vz_s5, vz_s6;

	logic signed [AXW-1:0] ax_s3;
	logic signed [AYW-1:0] ay_s3;

	logic signed [HXW-1:0] hx_s4;
	logic signed [HYW-1:0] hy_s4;
	logic [LW-1:0]         lx_s4, ly_s4;

	logic signed [RXW-1:0] rx_s5;
	logic signed [RYW-1:0] ry_s5;

	logic signed [NYW-1:0] ny;
	logic [31:0]           x_sat, y_sat;
	logic [31:0]           x_s6, y_s6;
	logic                  last_s6;

	// The whole pipeline moves together whenever the output register can take data.
	assign en    = !vld_s6 || !vertex_stall;
	assign issue = en && !empty;
	assign pop   = issue && (slot_q == SLOT_LAST);
	assign crn   = slot_corner(slot_q);

	always_comb begin
		unique case (crn)
			CRN_00: begin
				sel_pix = head_quad.p00;
				sel_col = head_col - CW'(1);
				sel_row = head_row - ROW_W'(1);
			end
			CRN_01: begin
				sel_pix = head_quad.p01;
				sel_col = head_col;
				sel_row = head_row - ROW_W'(1);
			end
			CRN_10: begin
				sel_pix = head_quad.p10;
				sel_col = head_col - CW'(1);
				sel_row = head_row;
			end
			CRN_11: begin
				sel_pix = head_quad.p11;
				sel_col = head_col;
				sel_row = head_row;
			end
			default: begin
				sel_pix = head_quad.p11;
				sel_col = head_col;
				sel_row = head_row;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_FIRST;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= !empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			if (!empty) begin
				slot_q <= (slot_q == SLOT_LAST) ? SLOT_FIRST : slot_q + slot_t'(1);
			end
		end
	end

	// z = 1 - Z, which can fall below the Q16.16 range for large depths.
	always_comb begin
		dz = ONE_Q16 - $signed({2'b00, z_s1});
		if ((&dz[33:31]) || !(|dz[33:31])) begin
			vz_s2_d = dz[31:0];
		end else begin
			vz_s2_d = dz[33] ? SAT_MIN : SAT_MAX;
		end
	end

	// Rounding to nearest, ties away from zero: a negative product takes a bias one short of half.
	always_comb begin
		if ((&rx_s5[RXW-1:31]) || !(|rx_s5[RXW-1:31])) begin
			x_sat = rx_s5[31:0];
		end else begin
			x_sat = rx_s5[RXW-1] ? SAT_MIN : SAT_MAX;
		end
		ny = -NYW'(ry_s5);
		if ((&ny[NYW-1:31]) || !(|ny[NYW-1:31])) begin
			y_sat = ny[31:0];
		end else begin
			y_sat = ny[NYW-1] ? SAT_MIN : SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1  <= sel_col;
			row_s1  <= sel_row;
			z_s1    <= sel_pix.depth;
			rgb_s1  <= {sel_pix.red, sel_pix.green, sel_pix.blue};
			slot_s1 <= slot_q;

			mx_s2   <= $signed(coef.scale_x) * $signed({1'b0, col_s1});
			my_s2   <= $signed(coef.scale_y) * $signed({1'b0, row_s1});
			vz_s2   <= vz_s2_d;
			z_s2    <= z_s1;
			rgb_s2  <= rgb_s1;
			slot_s2 <= slot_s1;

			ax_s3   <= AXW'(mx_s2) + AXW'($signed(coef.offset_x));
			ay_s3   <= AYW'(my_s2) + AYW'($signed(coef.offset_y));
			vz_s3   <= vz_s2;
			z_s3    <= z_s2;
			rgb_s3  <= rgb_s2;
			slot_s3 <= slot_s2;

			hx_s4   <= $signed(ax_s3[AXW-1:QFRAC]) * $signed({1'b0, z_s3});
			hy_s4   <= $signed(ay_s3[AYW-1:QFRAC]) * $signed({1'b0, z_s3});
			lx_s4   <= LW'(ax_s3[QFRAC-1:0]) * LW'(z_s3)
				+ LW'(ax_s3[AXW-1] ? HALF_M1 : HALF);
			ly_s4   <= LW'(ay_s3[QFRAC-1:0]) * LW'(z_s3)
				+ LW'(ay_s3[AYW-1] ? HALF_M1 : HALF);
			vz_s4   <= vz_s3;
			rgb_s4  <= rgb_s3;
			slot_s4 <= slot_s3;

			rx_s5   <= RXW'(hx_s4) + RXW'($signed({1'b0, lx_s4[LW-1:QFRAC]}));
			ry_s5   <= RYW'(hy_s4) + RYW'($signed({1'b0, ly_s4[LW-1:QFRAC]}));
			vz_s5   <= vz_s4;
			rgb_s5  <= rgb_s4;
			slot_s5 <= slot_s4;

			x_s6    <= x_sat;
			y_s6    <= y_sat;
			vz_s6   <= vz_s5;
			rgb_s6  <= rgb_s5;
			slot_s6 <= slot_s5;
			last_s6 <= slot_s5 == SLOT_LAST;
		end
	end

	assign vertex_valid = vld_s6;
	assign vertex_x     = $signed(x_s6);
	assign vertex_y     = $signed(y_s6);
	assign vertex_z     = $signed(vz_s6);
	assign vertex_red   = rgb_s6[47:32];
	assign vertex_green = rgb_s6[31:16];
	assign vertex_blue  = rgb_s6[15:0];
	assign vertex_slot  = slot_s6;
	assign quad_last    = last_s6;

endmodule

// File: rtl/depth_map_to_triangle_mesh_top.sv
// Depth map to triangle mesh: raster pixels with depth and colour in, mesh
// vertices out. A front end accepts one pixel per cycle while the two-entry
// quad queue has room; every pixel that closes a 2x2 quad of valid depths
// yields six vertices, which the vertex pipeline issues one per cycle while its
// output is not stalled. Other pixels go on at one per cycle, while a stream of
// quad-closing pixels is paced by the vertex issue once the queue fills. The
// vertices of a quad pass through the registered vertex pipeline, and a pixel
// is registered in the front end before it reaches the queue. The previous
// image line lives in one MAX_WIDTH by 81-bit memory with one write and one
// read a pixel; it needs no clearing after reset. Configuration registers are
// written by index and should be changed only while no pixel or vertex is in flight.
// Holds the configuration registers; uses dmtm_pkg, dmtm_front, dmtm_queue, dmtm_back.
module depth_map_to_triangle_mesh_top #(
	parameter int MAX_WIDTH = dmtm_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [dmtm_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [dmtm_pkg::CFG_DATA_W-1:0]   wr_data,
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  logic [31:0]                       depth,
	input  logic                              depth_valid,
	input  logic [15:0]                       red,
	input  logic [15:0]                       green,
	input  logic [15:0]                       blue,
	input  logic                              frame_start,
	output logic                              vertex_valid,
	input  logic                              vertex_stall,
	output logic signed [31:0]                vertex_x,
	output logic signed [31:0]                vertex_y,
	output logic signed [31:0]                vertex_z,
	output logic [15:0]                       vertex_red,
	output logic [15:0]                       vertex_green,
	output logic [15:0]                       vertex_blue,
	output logic [2:0]                        vertex_slot,
	output logic                              quad_last
);
	import dmtm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [IMAGE_WIDTH_W-1:0] image_width_q;
	coef_t                    coef_q;

	logic             push;
	logic [CW-1:0]    push_col;
	logic [ROW_W-1:0] push_row;
	quad_t            push_quad;
	logic             q_full;
	logic             pop;
	logic             q_empty;
	logic [CW-1:0]    head_col;
	logic [ROW_W-1:0] head_row;
	quad_t            head_quad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			coef_q        <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_IMAGE_WIDTH: image_width_q   <= wr_data[IMAGE_WIDTH_W-1:0];
				REG_SCALE_X:     coef_q.scale_x  <= $signed(wr_data);
				REG_OFFSET_X:    coef_q.offset_x <= $signed(wr_data);
				REG_SCALE_Y:     coef_q.scale_y  <= $signed(wr_data);
				REG_OFFSET_Y:    coef_q.offset_y <= $signed(wr_data);
				default: begin
				end
			endcase
		end
	end

	dmtm_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.image_width(image_width_q),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.depth      (depth),
		.depth_valid(depth_valid),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.frame_start(frame_start),
		.push       (push),
		.push_col   (push_col),
		.push_row   (push_row),
		.push_quad  (push_quad),
		.q_full     (q_full)
	);

	dmtm_queue #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_col (push_col),
		.push_row (push_row),
		.push_quad(push_quad),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head_col (head_col),
		.head_row (head_row),
		.head_quad(head_quad)
	);

	dmtm_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef        (coef_q),
		.empty       (q_empty),
		.pop         (pop),
		.head_col    (head_col),
		.head_row    (head_row),
		.head_quad   (head_quad),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.vertex_z    (vertex_z),
		.vertex_red  (vertex_red),
		.vertex_green(vertex_green),
		.vertex_blue (vertex_blue),
		.vertex_slot (vertex_slot),
		.quad_last   (quad_last)
	);

endmodule

// File: rtl/dmtm_checker.sv
// Port checker for the vertex channel of the mesh block, bound to the top level.
// Uses dmtm_pkg.
module dmtm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        vertex_valid,
	input logic        vertex_stall,
	input logic [31:0] vertex_x,
	input logic [31:0] vertex_y,
	input logic [31:0] vertex_z,
	input logic [2:0]  vertex_slot,
	input logic        quad_last
);
	import dmtm_pkg::*;

	// Only the six slots of a quad exist, and only the sixth closes it.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> (vertex_slot <= SLOT_LAST)
			&& (quad_last == (vertex_slot == SLOT_LAST)))
		else $error("vertex slot out of range or quad_last misplaced");

	// The vertices of one quad leave back to back once a transfer has started it.
	a_slot_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && !vertex_stall && (vertex_slot != SLOT_LAST)) |=>
			(vertex_valid && (vertex_slot == $past(vertex_slot) + 3'd1)))
		else $error("quad vertices not in consecutive slots");

	// After an idle cycle the next vertex opens a new quad.
	a_quad_start: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && !$past(vertex_valid)) |-> (vertex_slot == SLOT_FIRST))
		else $error("vertex stream resumed in the middle of a quad");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && vertex_stall) |=>
			(vertex_valid && $stable(vertex_x) && $stable(vertex_y)
				&& $stable(vertex_z) && $stable(vertex_slot)))
		else $error("stalled vertex changed");

endmodule

bind depth_map_to_triangle_mesh_top dmtm_checker u_dmtm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.vertex_valid(vertex_valid),
	.vertex_stall(vertex_stall),
	.vertex_x    (vertex_x),
	.vertex_y    (vertex_y),
	.vertex_z    (vertex_z),
	.vertex_slot (vertex_slot),
	.quad_last   (quad_last)
);

// File: sim/depth_map_to_triangle_mesh_top_tb.sv
// Self-checking bench for the depth map to triangle mesh block: drives raster pixels,
// predicts every mesh vertex and compares each vertex transfer field by field.
// Depends on dmtm_pkg and depth_map_to_triangle_mesh_top.
module depth_map_to_triangle_mesh_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dmtm_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;
	localparam int ROW_LIMIT = (1 << ROW_W) - 1;

	typedef struct packed {
		logic [31:0] depth;
		logic        depth_valid;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        frame_start;
		logic        drain;
	} pixel_item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        red;
		logic [15:0]        green;
		logic [15:0]        blue;
		logic [2:0]         slot;
		logic               last;
	} vertex_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  pixel_valid = 1'b0;
	logic                  pixel_stall;
	logic [31:0]           depth = '0;
	logic                  depth_valid = 1'b0;
	logic [15:0]           red = '0;
	logic [15:0]           green = '0;
	logic [15:0]           blue = '0;
	logic                  frame_start = 1'b0;
	logic                  vertex_valid;
	logic                  vertex_stall = 1'b0;
	logic signed [31:0]    vertex_x;
	logic signed [31:0]    vertex_y;
	logic signed [31:0]    vertex_z;
	logic [15:0]           vertex_red;
	logic [15:0]           vertex_green;
	logic [15:0]           vertex_blue;
	logic [2:0]            vertex_slot;
	logic                  quad_last;

	depth_map_to_triangle_mesh_top dut (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data,
		.pixel_valid, .pixel_stall, .depth, .depth_valid, .red, .green, .blue, .frame_start,
		.vertex_valid, .vertex_stall, .vertex_x, .vertex_y, .vertex_z,
		.vertex_red, .vertex_green, .vertex_blue, .vertex_slot, .quad_last
	);

	always #2 clk = ~clk;

	pixel_item_t pixel_q[$];
	vertex_t     vertex_due_q[$];

	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     fail_count = 0;
	longint cycle_count = 0;
	longint cycle_limit = 20000;
	bit     hold_go = 1'b0;
	bit     hold_used;
	int     hold_left;

	// Mirror of the block's configuration and line state.
	logic [IMAGE_WIDTH_W-1:0] cfg_width = IMAGE_WIDTH_RST;
	logic signed [31:0]       cfg_scale_x = '0;
	logic signed [31:0]       cfg_offset_x = '0;
	logic signed [31:0]       cfg_scale_y = '0;
	logic signed [31:0]       cfg_offset_y = '0;
	logic [32:0]              line_depth [MAX_WIDTH_DEF];
	logic [47:0]              line_color [MAX_WIDTH_DEF];
	logic [32:0]              left_depth = '0;
	logic [47:0]              left_color = '0;
	int                       mesh_col = 0;
	int                       mesh_row = 0;

	// Product a*z shifted down by the Q8.24 fraction, rounded on its magnitude so halves go away from zero.
	function automatic longint round_q24_product(longint a, logic [31:0] z);
		logic [63:0]  mag;
		logic [127:0] prod;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		prod = {64'd0, mag} * {96'd0, z};
		prod = (prod + 128'h80_0000) >> QFRAC;
		return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic logic [31:0] clamp_s32(longint v);
		if (v > 64'sd2147483647)
			return SAT_MAX;
		if (v < -64'sd2147483648)
			return SAT_MIN;
		return v[31:0];
	endfunction

	function automatic vertex_t corner_vertex(int col, int row, logic [32:0] d,
			logic [47:0] rgb, int k);
		vertex_t v;
		longint  ax;
		longint  ay;
		ax = longint'(cfg_scale_x) * col + longint'(cfg_offset_x);
		ay = longint'(cfg_scale_y) * row + longint'(cfg_offset_y);
		v.x = clamp_s32(round_q24_product(ax, d[31:0]));
		v.y = clamp_s32(-round_q24_product(ay, d[31:0]));
		v.z = clamp_s32(longint'(ONE_Q16) - longint'(d[31:0]));
		v.red = rgb[47:32];
		v.green = rgb[31:16];
		v.blue = rgb[15:0];
		v.slot = 3'(k);
		v.last = (3'(k) == SLOT_LAST);
		return v;
	endfunction

	task automatic add_due_vertex(vertex_t v);
		vertex_due_q = {vertex_due_q, v};
	endtask

	task automatic unproject_pixel(pixel_item_t p);
		int          w;
		int          c;
		int          r;
		int          idx;
		logic [32:0] dcur;
		logic [32:0] d00;
		logic [32:0] d01;
		logic [47:0] ccur;
		logic [47:0] c00;
		logic [47:0] c01;
		w = int'(cfg_width);
		if (w < 2)
			w = 2;
		if (w > MAX_WIDTH_DEF)
			w = MAX_WIDTH_DEF;
		dcur = {p.depth_valid, p.depth};
		ccur = {p.red, p.green, p.blue};
		if (p.frame_start) begin
			mesh_col = 0;
			mesh_row = 0;
		end else if (mesh_col >= w) begin
			mesh_col = 0;
			if (mesh_row < ROW_LIMIT)
				mesh_row++;
		end
		c = mesh_col;
		r = mesh_row;
		if (r >= 1 && c >= 1) begin
			d00 = line_depth[c-1];
			c00 = line_color[c-1];
			d01 = line_depth[c];
			c01 = line_color[c];
			if (d00[32] && d01[32] && left_depth[32] && dcur[32]) begin
				add_due_vertex(corner_vertex(c - 1, r - 1, d00, c00, 0));
				add_due_vertex(corner_vertex(c, r, dcur, ccur, 1));
				add_due_vertex(corner_vertex(c, r - 1, d01, c01, 2));
				add_due_vertex(corner_vertex(c, r, dcur, ccur, 3));
				add_due_vertex(corner_vertex(c - 1, r - 1, d00, c00, 4));
				add_due_vertex(corner_vertex(c - 1, r, left_depth, left_color, 5));
			end
		end
		// The pixel to the left goes into the line only now; at column 0 it closes the row.
		idx = (c >= 1) ? c - 1 : w - 1;
		line_depth[idx] = left_depth;
		line_color[idx] = left_color;
		left_depth = dcur;
		left_color = ccur;
		mesh_col = c + 1;
		if (mesh_col >= w) begin
			mesh_col = 0;
			if (mesh_row < ROW_LIMIT)
				mesh_row++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : pixel_driver
		bit taken;
		taken = 1'b0;
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else begin
			if (pixel_valid && !pixel_stall) begin
				unproject_pixel(pixel_q.pop_front());
				taken = 1'b1;
			end
			if (!pixel_valid || taken) begin
				if (pixel_q.size() != 0 && !(pixel_q[0].drain && vertex_due_q.size() != 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					pixel_valid <= 1'b1;
					depth <= pixel_q[0].depth;
					depth_valid <= pixel_q[0].depth_valid;
					red <= pixel_q[0].red;
					green <= pixel_q[0].green;
					blue <= pixel_q[0].blue;
					frame_start <= pixel_q[0].frame_start;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : vertex_monitor
		vertex_t got;
		vertex_t want;
		if (!arst_n) begin
			vertex_stall <= 1'b0;
		end else begin
			if (vertex_valid && !vertex_stall) begin
				got = {vertex_x, vertex_y, vertex_z, vertex_red, vertex_green, vertex_blue,
					vertex_slot, quad_last};
				if (vertex_due_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("unexpected vertex: x=%0d y=%0d z=%0d slot=%0d",
							got.x, got.y, got.z, got.slot);
				end else begin
					want = vertex_due_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display({"vertex mismatch: expected x=%0d y=%0d z=%0d rgb=%h/%h/%h",
								" slot=%0d last=%b, got x=%0d y=%0d z=%0d rgb=%h/%h/%h",
								" slot=%0d last=%b"},
								want.x, want.y, want.z, want.red, want.green, want.blue,
								want.slot, want.last, got.x, got.y, got.z, got.red,
								got.green, got.blue, got.slot, got.last);
					end
				end
			end
			vertex_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// One long hold-off of the vertex side so that the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_go && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > cycle_limit) begin
			$display("** depth_map_to_triangle_mesh_top: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] rand_depth();
		if ($urandom_range(3) == 0)
			return $urandom;
		return 32'($urandom_range(0, 32'h000A_0000));
	endfunction

	function automatic logic [47:0] rand_rgb();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(5))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return $urandom;
			default: return 32'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	task automatic queue_pixel(logic [31:0] d, logic dv, logic [47:0] rgb, logic fs,
			logic drain);
		pixel_item_t p;
		int          gap;
		int          stall;
		p.depth = d;
		p.depth_valid = dv;
		p.red = rgb[47:32];
		p.green = rgb[31:16];
		p.blue = rgb[15:0];
		p.frame_start = fs;
		p.drain = drain;
		pixel_q = {pixel_q, p};
		gap = 100 / (100 - send_idle_pct) + 1;
		stall = 100 / (100 - recv_stall_pct) + 1;
		cycle_limit += 4 * (gap + 2 + (dv ? 6 * stall : 0));
	endtask

	// Waits until every pixel has been taken and every vertex has left, then lets
	// the pipeline run dry, since the last pixel may have closed no quad.
	task automatic wait_idle();
		while (pixel_q.size() != 0 || vertex_due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cycle_limit += 4 * SETTLE_CYCLES;
	endtask

	task automatic idle_then(int send_pct, int recv_pct);
		wait_idle();
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: cfg_width = value[IMAGE_WIDTH_W-1:0];
			REG_SCALE_X:     cfg_scale_x = value;
			REG_OFFSET_X:    cfg_offset_x = value;
			REG_SCALE_Y:     cfg_scale_y = value;
			REG_OFFSET_Y:    cfg_offset_y = value;
			default:         ;
		endcase
	endtask

	task automatic configure(logic [11:0] w, logic [31:0] sx, logic [31:0] ox,
			logic [31:0] sy, logic [31:0] oy);
		write_reg(REG_IMAGE_WIDTH, {20'd0, w});
		write_reg(REG_SCALE_X, sx);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_SCALE_Y, sy);
		write_reg(REG_OFFSET_Y, oy);
		@(negedge clk);
	endtask

	initial begin : stimulus
		int i;
		int ph;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: a 640-pixel line, so the start of the first row closes no quad.
		queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b1, 1'b0);
		for (i = 1; i < 6; i++)
			queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b0, 1'b0);

		// Width zero clamps to two; extreme terms and extreme depths and colours.
		idle_then(0, 0);
		configure(12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_pixel(32'd0, 1'b1, 48'd0, 1'b1, 1'b0);
		queue_pixel(32'hFFFF_FFFF, 1'b1, {48{1'b1}}, 1'b0, 1'b0);
		queue_pixel(32'd1, 1'b1, {16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, 1'b0);
		queue_pixel(32'h0001_0000, 1'b1, {16'h0000, 16'hFFFF, 16'h0000}, 1'b0, 1'b0);
		// Invalid corners, each in a different position of the quad.
		queue_pixel(32'hFFFF_FFFF, 1'b0, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(32'd123456, 1'b1, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(32'h0000_FFFF, 1'b1, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(32'd0, 1'b0, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(32'd2, 1'b1, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(32'hFFFF_FFFF, 1'b1, rand_rgb(), 1'b0, 1'b0);
		// A new image that starts in the middle of a row.
		queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b1, 1'b0);
		queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b0, 1'b0);
		queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b0, 1'b0);

		// Half-pixel offsets with odd depths land exactly on rounding ties.
		idle_then(0, 0);
		configure(12'd1, 32'h0100_0000, 32'hFF80_0000, 32'hFF00_0000, 32'h0080_0000);
		for (i = 0; i < 8; i++)
			queue_pixel(rand_depth() | 32'd1, 1'b1, rand_rgb(), i == 0, 1'b0);

		// The width shrinks in the middle of an image, past the current column.
		idle_then(0, 0);
		configure(12'd8, rand_coef(), rand_coef(), rand_coef(), rand_coef());
		for (i = 0; i < 14; i++)
			queue_pixel(rand_depth(), 1'b1, rand_rgb(), i == 0, 1'b0);
		idle_then(0, 0);
		write_reg(REG_IMAGE_WIDTH, 32'd4);
		@(negedge clk);
		for (i = 0; i < 8; i++)
			queue_pixel(rand_depth(), 1'b1, rand_rgb(), 1'b0, 1'b0);

		// Random images, one phase per idling pattern. The first phase uses two-pixel
		// rows of valid depths so that quads pile up behind the long hold-off.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       idle_then(0, 0);
				1:       idle_then(83, 0);
				2:       idle_then(0, 83);
				default: idle_then(24, 24);
			endcase
			configure((ph == 0) ? 12'd2 : 12'($urandom_range(2, 6)), rand_coef(),
				rand_coef(), rand_coef(), rand_coef());
			if (ph == 0) begin
				hold_go = 1'b1;
				cycle_limit += 4 * HOLD_CYCLES;
			end
			for (i = 0; i < 14; i++)
				queue_pixel(rand_depth(), ph == 0 || $urandom_range(99) < 88, rand_rgb(),
					i == 0 || (ph != 0 && $urandom_range(99) < 4),
					ph != 0 && i != 0 && (i == 7 || $urandom_range(99) < 5));
		end

		wait_idle();
		if (fail_count == 0)
			$display("** depth_map_to_triangle_mesh_top: PASSED **");
		else
			$display("** depth_map_to_triangle_mesh_top: FAILED **");
		$finish;
	end

endmodule
